/* hdl/lcds_pkg.sv */
package lcds_pkg;

    localparam int HEIGHT_W   = 16;
    localparam int INDEX_W    = 4;
    localparam int BOUND_W    = 12;
    localparam int DOSE_W     = 12;
    localparam int COUNT_W    = 10;
    localparam int WSUM_W     = 19;
    localparam int ENTRIES_W  = 5;
    localparam int TICKS_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int FRAC_SCALE = 16;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_TABLE_ENTRIES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_OFFSET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_TICKS = 2'd2;

    localparam logic [ENTRIES_W-1:0]       ENTRIES_RST = 5'd0;
    localparam logic signed [HEIGHT_W-1:0] OFFSET_RST  = 16'sd160;
    localparam logic [TICKS_W-1:0]         TICKS_RST   = 16'd360;

    typedef struct packed {
        logic signed [BOUND_W-1:0] lower;
        logic signed [BOUND_W-1:0] upper;
        logic [DOSE_W-1:0]         dose;
        logic [COUNT_W-1:0]        count;
    } entry_t;

endpackage

/* hdl/lcds_if.sv */
interface lcds_req_if import lcds_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic signed [HEIGHT_W-1:0] measured_height;
    logic [INDEX_W-1:0]         entry_index;
    logic signed [BOUND_W-1:0]  entry_lower;
    logic signed [BOUND_W-1:0]  entry_upper;
    logic [DOSE_W-1:0]          entry_dose;
    logic [COUNT_W-1:0]         entry_count;

    modport source (output valid, opcode, measured_height, entry_index, entry_lower,
                    entry_upper, entry_dose, entry_count, input ready);
    modport sink   (input valid, opcode, measured_height, entry_index, entry_lower,
                    entry_upper, entry_dose, entry_count, output ready);
endinterface

interface lcds_res_if import lcds_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     inject;
    logic [DOSE_W-1:0]        dose;
    logic [INDEX_W-1:0]       matched_entry;
    logic [COUNT_W-1:0]       remaining_count;
    logic                     cooling;
    logic signed [WSUM_W-1:0] window_sum;

    modport source (output valid, inject, dose, matched_entry, remaining_count, cooling,
                    window_sum, input ready);
    modport sink   (input valid, inject, dose, matched_entry, remaining_count, cooling,
                    window_sum, output ready);
endinterface

/* hdl/level_class_dose_scheduler.sv */
// channel | dir | handshake     | payload
// req     | in  | valid / ready | opcode, measured_height, entry_index, entry bounds/dose/count
// res     | out | valid / ready | inject, dose, matched_entry, remaining_count, cooling, window_sum
// cfg     | in  | cfg_we        | cfg_index, cfg_data (no read-back)
//
// Load item: the table entry is written on accept; ready returns as ST_FIN loads the result register.
// Sample item: ST_SUM, then ST_SCAN over up to min(table_entries, TABLE_DEPTH) entries when
// injection is enabled, then ST_FIN; one shared adder sums the history, then one entry is
// read from the class table each cycle and compared against the window sum.
// req.ready is high only between items; a held result delays the next result, not its accept.
// Reset clears history, sum and cooldown, sets enable and loads config defaults; the class table is not cleared.
module level_class_dose_scheduler import lcds_pkg::*; #(
    parameter int TABLE_DEPTH = 16,
    parameter int WINDOW_LEN  = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    lcds_req_if.sink              req,
    lcds_res_if.source            res
);

    localparam int TA_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PTR_W = $clog2(TABLE_DEPTH + 1);
    localparam int HI_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W = HEIGHT_W + $clog2(WINDOW_LEN);
    localparam int BND_W = BOUND_W + $clog2(WINDOW_LEN * FRAC_SCALE + 1) + 1;
    localparam int CMP_W = ((SUM_W > BND_W) ? SUM_W : BND_W) + 1;
    localparam logic signed [CMP_W-1:0] SCALE = CMP_W'(WINDOW_LEN * FRAC_SCALE);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic signed [HEIGHT_W-1:0] hist_reg [WINDOW_LEN];
    logic signed [HEIGHT_W-1:0] hist_next [WINDOW_LEN];
    logic signed [SUM_W-1:0]    acc_reg, acc_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       search_reg, search_next;
    logic                       enable_reg, enable_next;
    logic [TICKS_W-1:0]         cool_reg, cool_next;
    logic [ENTRIES_W-1:0]       entries_reg;
    logic signed [HEIGHT_W-1:0] offset_reg;
    logic [TICKS_W-1:0]         ticks_reg;
    logic [PTR_W-1:0]           lim_reg, lim_next;
    logic [PTR_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic                       cmpv_reg, cmpv_next;
    logic [TA_W-1:0]            cmp_idx_reg, cmp_idx_next;
    logic                       hit_reg, hit_next;
    logic [DOSE_W-1:0]          dose_reg, dose_next;
    logic [INDEX_W-1:0]         midx_reg, midx_next;
    logic [COUNT_W-1:0]         remain_reg, remain_next;
    logic                       res_valid_reg, res_valid_next;

    logic                       res_inject_reg;
    logic [DOSE_W-1:0]          res_dose_reg;
    logic [INDEX_W-1:0]         res_midx_reg;
    logic [COUNT_W-1:0]         res_remain_reg;
    logic                       res_cooling_reg;
    logic signed [WSUM_W-1:0]   res_wsum_reg;
    logic                       res_load;

    entry_t                     mem [TABLE_DEPTH];
    entry_t                     rd_data_reg;
    entry_t                     wdata;
    logic                       we;
    logic [TA_W-1:0]            waddr;
    logic                       rd_en;

    logic                       accept;
    logic signed [HEIGHT_W:0]   diff_wide;
    logic signed [HEIGHT_W-1:0] diff_sat;
    logic signed [HEIGHT_W-1:0] hist_rd;
    logic signed [SUM_W-1:0]    acc_sum;
    logic signed [CMP_W-1:0]    sum_ext;
    logic signed [CMP_W-1:0]    lo_bound;
    logic signed [CMP_W-1:0]    hi_bound;
    logic                       match;
    logic [TICKS_W:0]           cool_inc;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);

    assign diff_wide = (HEIGHT_W+1)'(req.measured_height) - (HEIGHT_W+1)'(offset_reg);
    assign diff_sat  = (diff_wide[HEIGHT_W] != diff_wide[HEIGHT_W-1])
                     ? {diff_wide[HEIGHT_W], {(HEIGHT_W-1){~diff_wide[HEIGHT_W]}}}
                     : diff_wide[HEIGHT_W-1:0];

    assign hist_rd  = hist_reg[cnt_reg[HI_W-1:0]];
    assign acc_sum  = acc_reg + SUM_W'(hist_rd);
    assign cool_inc = {1'b0, cool_reg} + (TICKS_W+1)'(1);

    assign sum_ext  = CMP_W'(sum_reg);
    assign lo_bound = CMP_W'(rd_data_reg.lower) * SCALE;
    assign hi_bound = CMP_W'(rd_data_reg.upper) * SCALE;
    assign match    = cmpv_reg && (sum_ext >= lo_bound) && (sum_ext < hi_bound)
                   && (rd_data_reg.count != '0);

    assign rd_en    = (state_reg == ST_SCAN) && !match && (rd_ptr_reg < lim_reg);
    assign res_load = (state_reg == ST_FIN) && (!res_valid_reg || res.ready);

    always_comb
    begin
        we    = 1'b0;
        waddr = cmp_idx_reg;
        wdata = rd_data_reg;
        if (accept && req.opcode == OP_LOAD && int'(req.entry_index) < TABLE_DEPTH)
        begin
            we          = 1'b1;
            waddr       = TA_W'(req.entry_index);
            wdata.lower = req.entry_lower;
            wdata.upper = req.entry_upper;
            wdata.dose  = req.entry_dose;
            wdata.count = req.entry_count;
        end
        else if (state_reg == ST_SCAN && match)
        begin
            we          = 1'b1;
            wdata.count = rd_data_reg.count - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_ptr_reg[TA_W-1:0]];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        hist_next    = hist_reg;
        acc_next     = acc_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        search_next  = search_reg;
        enable_next  = enable_reg;
        cool_next    = cool_reg;
        lim_next     = lim_reg;
        rd_ptr_next  = rd_ptr_reg;
        cmpv_next    = cmpv_reg;
        cmp_idx_next = cmp_idx_reg;
        hit_next     = hit_reg;
        dose_next    = dose_reg;
        midx_next    = midx_reg;
        remain_next  = remain_reg;
        res_valid_next = res_valid_reg && !res.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    hit_next    = 1'b0;
                    dose_next   = '0;
                    midx_next   = '0;
                    remain_next = '0;
                    if (req.opcode == OP_LOAD)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        for (int i = 0; i < WINDOW_LEN - 1; i++)
                        begin
                            hist_next[i] = hist_reg[i+1];
                        end
                        hist_next[WINDOW_LEN-1] = diff_sat;
                        acc_next    = '0;
                        cnt_next    = '0;
                        search_next = enable_reg;
                        lim_next    = (int'(entries_reg) > TABLE_DEPTH)
                                    ? PTR_W'(TABLE_DEPTH) : PTR_W'(entries_reg);
                        if (!enable_reg)
                        begin
                            if (cool_inc >= {1'b0, ticks_reg})
                            begin
                                enable_next = 1'b1;
                                cool_next   = '0;
                            end
                            else
                            begin
                                cool_next = cool_inc[TICKS_W-1:0];
                            end
                        end
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                acc_next = acc_sum;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(WINDOW_LEN - 1))
                begin
                    sum_next    = acc_sum;
                    rd_ptr_next = '0;
                    cmpv_next   = 1'b0;
                    if (search_reg && lim_reg != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    hit_next    = 1'b1;
                    dose_next   = rd_data_reg.dose;
                    midx_next   = INDEX_W'(cmp_idx_reg);
                    remain_next = rd_data_reg.count - COUNT_W'(1);
                    enable_next = 1'b0;
                    state_next  = ST_FIN;
                end
                else if (rd_ptr_reg < lim_reg)
                begin
                    cmp_idx_next = rd_ptr_reg[TA_W-1:0];
                    cmpv_next    = 1'b1;
                    rd_ptr_next  = rd_ptr_reg + PTR_W'(1);
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (res_load)
                begin
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                hist_reg[i] <= '0;
            end
            sum_reg       <= '0;
            search_reg    <= 1'b0;
            enable_reg    <= 1'b1;
            cool_reg      <= '0;
            entries_reg   <= ENTRIES_RST;
            offset_reg    <= OFFSET_RST;
            ticks_reg     <= TICKS_RST;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hist_reg      <= hist_next;
            sum_reg       <= sum_next;
            search_reg    <= search_next;
            enable_reg    <= enable_next;
            cool_reg      <= cool_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TABLE_ENTRIES:  entries_reg <= cfg_data[ENTRIES_W-1:0];
                    REG_HEIGHT_OFFSET:  offset_reg  <= cfg_data;
                    REG_COOLDOWN_TICKS: ticks_reg   <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        cnt_reg     <= cnt_next;
        lim_reg     <= lim_next;
        rd_ptr_reg  <= rd_ptr_next;
        cmpv_reg    <= cmpv_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_reg     <= hit_next;
        dose_reg    <= dose_next;
        midx_reg    <= midx_next;
        remain_reg  <= remain_next;
        if (res_load)
        begin
            res_inject_reg  <= hit_reg;
            res_dose_reg    <= dose_reg;
            res_midx_reg    <= midx_reg;
            res_remain_reg  <= remain_reg;
            res_cooling_reg <= !enable_reg;
            res_wsum_reg    <= WSUM_W'(sum_reg);
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.inject          = res_inject_reg;
    assign res.dose            = res_dose_reg;
    assign res.matched_entry   = res_midx_reg;
    assign res.remaining_count = res_remain_reg;
    assign res.cooling         = res_cooling_reg;
    assign res.window_sum      = res_wsum_reg;

endmodule

/* hdl/lcds_checker.sv */
module lcds_checker import lcds_pkg::*; (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_valid,
    input logic                     req_ready,
    input logic                     res_valid,
    input logic                     res_ready,
    input logic                     res_inject,
    input logic [DOSE_W-1:0]        res_dose,
    input logic [INDEX_W-1:0]       res_matched_entry,
    input logic [COUNT_W-1:0]       res_remaining_count,
    input logic                     res_cooling,
    input logic signed [WSUM_W-1:0] res_window_sum
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_inject) && $stable(res_dose)
            && $stable(res_matched_entry) && $stable(res_remaining_count)
            && $stable(res_cooling) && $stable(res_window_sum))
        else $error("result item changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready stayed high after an accepted item");

    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_inject |-> res_dose == '0 && res_matched_entry == '0
            && res_remaining_count == '0)
        else $error("match fields set on an item without injection");

    a_inject_cools: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_inject |-> res_cooling)
        else $error("injection reported without cooldown");

endmodule

bind level_class_dose_scheduler lcds_checker u_lcds_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .res_valid           (res.valid),
    .res_ready           (res.ready),
    .res_inject          (res.inject),
    .res_dose            (res.dose),
    .res_matched_entry   (res.matched_entry),
    .res_remaining_count (res.remaining_count),
    .res_cooling         (res.cooling),
    .res_window_sum      (res.window_sum)
);
